[rtl/ubfc_pkg.sv]
// ----------------------------------------------------------------------------
// ubfc_pkg
// Word types, operation codes and error codes for the buffered UART FIFO
// controller.
// ----------------------------------------------------------------------------
package ubfc_pkg;

    localparam logic [2:0] OP_SEND   = 3'd0;
    localparam logic [2:0] OP_RECV   = 3'd1;
    localparam logic [2:0] OP_TXDONE = 3'd2;
    localparam logic [2:0] OP_RXBYTE = 3'd3;
    localparam logic [2:0] OP_RXERR  = 3'd4;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_FRAMING = 3'd1;
    localparam logic [2:0] ERR_PARITY  = 3'd2;
    localparam logic [2:0] ERR_OVERRUN = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_in;
        logic [2:0] error_flags;
    } in_t;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  read_data;
        logic        tx_start;
        logic [7:0]  tx_byte;
        logic        tx_idle;
        logic        rx_dropped;
        logic [2:0]  last_error;
        logic [15:0] error_total;
    } out_t;

endpackage

[rtl/uart_buffered_fifo_controller.sv]
// ----------------------------------------------------------------------------
// uart_buffered_fifo_controller
// Transmit and receive ring FIFOs for an interrupt-driven UART, with receive
// error classification and a wrapping error count.
// ----------------------------------------------------------------------------
// Channel   Ports                        Word
// input     s_valid s_ready s_data       ubfc_pkg::in_t  (operation event)
// result    m_valid m_ready m_data       ubfc_pkg::out_t (one per event)
//
// Pointers, flags and the FIFO write update for each word at the accepting
// edge, and the FIFO read port registers the popped byte at that same edge
// into the result stage. One word per cycle is sustained unless stalled.
// s_ready is high when the result stage is empty or is taken in that cycle.
// Reset empties both rings, marks the transmitter idle and clears the error
// state; ring contents are not cleared.
// ----------------------------------------------------------------------------
module uart_buffered_fifo_controller
    import ubfc_pkg::*;
#(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 128
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
    localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_rdata_reg;
    logic [7:0] tx_rdata_reg;

    logic [RX_PW-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TX_PW-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic [RX_PW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_PW-1:0] tx_wp_inc, tx_rp_inc;
    logic             tx_idle_reg, tx_idle_next;
    logic [2:0]       err_code_reg, err_code_next;
    logic [15:0]      err_cnt_reg, err_cnt_next;

    logic       m_valid_reg;
    logic       accepted_reg, accepted_next;
    logic       rx_pop_reg, rx_pop_next;
    logic       tx_pop_reg, tx_pop_next;
    logic       tx_start_reg, tx_start_next;
    logic       rx_drop_reg, rx_drop_next;
    logic [7:0] tx_direct_reg, tx_direct_next;

    logic accept;
    logic rx_push, tx_push;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;

    always_comb begin
        rx_wp_next     = rx_wp_reg;
        rx_rp_next     = rx_rp_reg;
        tx_wp_next     = tx_wp_reg;
        tx_rp_next     = tx_rp_reg;
        tx_idle_next   = tx_idle_reg;
        err_code_next  = err_code_reg;
        err_cnt_next   = err_cnt_reg;
        accepted_next  = 1'b0;
        rx_pop_next    = 1'b0;
        tx_pop_next    = 1'b0;
        tx_start_next  = 1'b0;
        rx_drop_next   = 1'b0;
        tx_direct_next = 8'd0;
        rx_push        = 1'b0;
        tx_push        = 1'b0;
        case (s_data.operation)
            OP_SEND: begin
                if (tx_idle_reg) begin
                    // bypass the ring straight to the transmitter
                    tx_idle_next   = 1'b0;
                    tx_start_next  = 1'b1;
                    tx_direct_next = s_data.data_in;
                    accepted_next  = 1'b1;
                end else if (tx_wp_inc != tx_rp_reg) begin
                    tx_push       = 1'b1;
                    tx_wp_next    = tx_wp_inc;
                    accepted_next = 1'b1;
                end
            end
            OP_RECV: begin
                if (rx_wp_reg != rx_rp_reg) begin
                    rx_pop_next   = 1'b1;
                    rx_rp_next    = rx_rp_inc;
                    accepted_next = 1'b1;
                end
            end
            OP_TXDONE: begin
                if (tx_wp_reg != tx_rp_reg) begin
                    tx_pop_next   = 1'b1;
                    tx_start_next = 1'b1;
                    tx_rp_next    = tx_rp_inc;
                end else begin
                    tx_idle_next = 1'b1;
                end
            end
            OP_RXBYTE: begin
                if (rx_wp_inc != rx_rp_reg) begin
                    rx_push    = 1'b1;
                    rx_wp_next = rx_wp_inc;
                end else begin
                    rx_drop_next = 1'b1;
                end
            end
            OP_RXERR: begin
                if (s_data.error_flags[0]) begin
                    err_code_next = ERR_FRAMING;
                end else if (s_data.error_flags[1]) begin
                    err_code_next = ERR_PARITY;
                end else if (s_data.error_flags[2]) begin
                    err_code_next = ERR_OVERRUN;
                end else begin
                    err_code_next = ERR_UNKNOWN;
                end
                err_cnt_next = err_cnt_reg + 16'd1;
            end
            default: begin
            end
        endcase
    end

    // ring storage: write on push, register the head byte on pop
    always_ff @(posedge aclk) begin
        if (accept && rx_push) begin
            rx_mem[rx_wp_reg] <= s_data.data_in;
        end
        if (accept && rx_pop_next) begin
            rx_rdata_reg <= rx_mem[rx_rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && tx_push) begin
            tx_mem[tx_wp_reg] <= s_data.data_in;
        end
        if (accept && tx_pop_next) begin
            tx_rdata_reg <= tx_mem[tx_rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wp_reg    <= '0;
            rx_rp_reg    <= '0;
            tx_wp_reg    <= '0;
            tx_rp_reg    <= '0;
            tx_idle_reg  <= 1'b1;
            err_code_reg <= ERR_NONE;
            err_cnt_reg  <= 16'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                rx_wp_reg    <= rx_wp_next;
                rx_rp_reg    <= rx_rp_next;
                tx_wp_reg    <= tx_wp_next;
                tx_rp_reg    <= tx_rp_next;
                tx_idle_reg  <= tx_idle_next;
                err_code_reg <= err_code_next;
                err_cnt_reg  <= err_cnt_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word fields; hold while the result stalls
    always_ff @(posedge aclk) begin
        if (accept) begin
            accepted_reg  <= accepted_next;
            rx_pop_reg    <= rx_pop_next;
            tx_pop_reg    <= tx_pop_next;
            tx_start_reg  <= tx_start_next;
            rx_drop_reg   <= rx_drop_next;
            tx_direct_reg <= tx_direct_next;
        end
    end

    // status fields track the state, which moves only when a new word loads
    assign m_valid              = m_valid_reg;
    assign m_data.accepted      = accepted_reg;
    assign m_data.read_data     = rx_pop_reg ? rx_rdata_reg : 8'd0;
    assign m_data.tx_start      = tx_start_reg;
    assign m_data.tx_byte       = tx_pop_reg ? tx_rdata_reg : tx_direct_reg;
    assign m_data.tx_idle       = tx_idle_reg;
    assign m_data.rx_dropped    = rx_drop_reg;
    assign m_data.last_error    = err_code_reg;
    assign m_data.error_total   = err_cnt_reg;

endmodule
